@@ rtl/rilbp_pkg.sv @@
// shared types, constants and the rotation-minimum function for the
// rotation-invariant 3x3 lbp core; no dependencies
package rilbp_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int PIXEL_BITS_DEF = 8;

	localparam int IN_PIXEL_W   = 8;
	localparam int CODE_W       = 8;
	localparam int N_NBR        = 8;
	localparam int WIDTH_REG_W  = 11;
	localparam int HEIGHT_REG_W = 16;
	localparam int CFG_DATA_W   = 16;
	localparam int CFG_INDEX_W  = 1;

	localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

	// per-pixel position flags handed from the window to the pipeline
	typedef struct packed {
		logic interior;
		logic row_end;
		logic last;
	} ctl_t;

	// smallest of the eight circular rotations of an 8-bit pattern
	function automatic logic [CODE_W-1:0] min_rotation(input logic [CODE_W-1:0] code);
		logic [2*CODE_W-1:0] dbl;
		logic [CODE_W-1:0]   best;
		logic [CODE_W-1:0]   rot;
		dbl  = {code, code};
		best = code;
		for (int k = 1; k < CODE_W; k++) begin
			rot = dbl[k +: CODE_W];
			if (rot < best) begin
				best = rot;
			end
		end
		return best;
	endfunction

endpackage

@@ rtl/rotation_invariant_lbp_3x3_core.sv @@
// top level of the rotation-invariant 3x3 lbp core
// depends on rilbp_pkg, rilbp_window (and through it rilbp_ram)

// Takes one grayscale pixel per clock in raster order and returns, for every
// interior pixel, the minimum circular rotation of its 8-neighbour comparison
// pattern (bit set where neighbour >= centre, clockwise from top-left), with
// row_end and last marking the last interior pixel of a row and of the frame.
// Border rows and columns give no output. Throughput is one pixel per clock
// while in_stall is low; the result is registered once after the comparisons
// and again in the output register after the rotation minimum. The two
// line stores are single-port-write, registered-read rams whose read address
// is prefetched from the column counter, which lets a pixel enter every cycle.
// image_width and image_height are clamped to at least 3 (width at most
// MAX_WIDTH) and should be written between frames. No clearing pass is needed
// after reset.
module rotation_invariant_lbp_3x3_core #(
	parameter int MAX_WIDTH  = rilbp_pkg::MAX_WIDTH_DEF,
	parameter int PIXEL_BITS = rilbp_pkg::PIXEL_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [rilbp_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [rilbp_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [rilbp_pkg::IN_PIXEL_W-1:0]  pixel,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [rilbp_pkg::CODE_W-1:0]      lbp_code,
	output logic                              row_end,
	output logic                              last
);
	import rilbp_pkg::*;

	logic                  in_acc;
	logic                  s2_take;
	logic [PIXEL_BITS-1:0] nbr [N_NBR];
	logic [PIXEL_BITS-1:0] ctr;
	ctl_t                  ctl;
	logic [CODE_W-1:0]     code_d;

	logic                  v_s1;
	logic [CODE_W-1:0]     code_s1;
	logic                  row_end_s1;
	logic                  last_s1;
	logic                  v_s2;
	logic [CODE_W-1:0]     code_s2;
	logic                  row_end_s2;
	logic                  last_s2;

	assign s2_take  = !v_s2 || !out_stall;
	assign in_stall = v_s1 && !s2_take;
	assign in_acc   = in_valid && !in_stall;

	rilbp_window #(
		.MAX_WIDTH (MAX_WIDTH),
		.PIXEL_BITS(PIXEL_BITS)
	) u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.accept   (in_acc),
		.pixel    (pixel),
		.nbr      (nbr),
		.ctr      (ctr),
		.ctl      (ctl)
	);

	always_comb begin
		for (int k = 0; k < N_NBR; k++) begin
			code_d[k] = nbr[k] >= ctr;
		end
	end

	// stage 1: comparison pattern
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!in_stall) begin
			v_s1 <= in_acc && ctl.interior;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			code_s1    <= code_d;
			row_end_s1 <= ctl.row_end;
			last_s1    <= ctl.last;
		end
	end

	// stage 2: rotation minimum into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_take) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_take) begin
			code_s2    <= min_rotation(code_s1);
			row_end_s2 <= row_end_s1;
			last_s2    <= last_s1;
		end
	end

	assign out_valid = v_s2;
	assign lbp_code  = code_s2;
	assign row_end   = row_end_s2;
	assign last      = last_s2;

endmodule

@@ rtl/rilbp_ram.sv @@
// generic single-write, single-read ram with registered read data
// no package dependencies
module rilbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

@@ rtl/rilbp_window.sv @@
// image geometry registers, column/row counters, two line stores and the
// 3x3 window; depends on rilbp_pkg and rilbp_ram
module rilbp_window #(
	parameter int MAX_WIDTH  = rilbp_pkg::MAX_WIDTH_DEF,
	parameter int PIXEL_BITS = rilbp_pkg::PIXEL_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [rilbp_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [rilbp_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                               accept,
	input  logic [rilbp_pkg::IN_PIXEL_W-1:0]   pixel,
	output logic [PIXEL_BITS-1:0]              nbr [rilbp_pkg::N_NBR],
	output logic [PIXEL_BITS-1:0]              ctr,
	output rilbp_pkg::ctl_t                    ctl
);
	import rilbp_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);

	logic [CW-1:0]           wlast_q;
	logic [HEIGHT_REG_W-1:0] hlast_q;
	logic [CW-1:0]           col_q;
	logic [HEIGHT_REG_W-1:0] row_q;
	logic [PIXEL_BITS-1:0]   win_q [6];

	logic [WIDTH_REG_W-1:0]  wv;
	logic [HEIGHT_REG_W-1:0] hv;
	logic [CW-1:0]           wlast_d;
	logic [HEIGHT_REG_W-1:0] hlast_d;
	logic                    col_last;
	logic                    row_last;
	logic [CW-1:0]           col_next;
	logic [CW-1:0]           rd_addr;
	logic [PIXEL_BITS-1:0]   bot;
	logic [PIXEL_BITS-1:0]   top;
	logic [PIXEL_BITS-1:0]   mid;

	generate
		if (PIXEL_BITS <= IN_PIXEL_W) begin : g_px_narrow
			assign bot = pixel[PIXEL_BITS-1:0];
		end else begin : g_px_wide
			assign bot = {{(PIXEL_BITS-IN_PIXEL_W){1'b0}}, pixel};
		end
	endgenerate

	// clamp the written geometry once, keep last column and last row
	always_comb begin
		wv = cfg_data[WIDTH_REG_W-1:0];
		hv = cfg_data[HEIGHT_REG_W-1:0];
		if (wv < WIDTH_REG_W'(3)) begin
			wlast_d = CW'(2);
		end else if (32'(wv) > 32'(MAX_WIDTH)) begin
			wlast_d = CW'(MAX_WIDTH - 1);
		end else begin
			wlast_d = CW'(wv - WIDTH_REG_W'(1));
		end
		if (hv < HEIGHT_REG_W'(3)) begin
			hlast_d = HEIGHT_REG_W'(2);
		end else begin
			hlast_d = hv - HEIGHT_REG_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlast_q <= CW'(2);
			hlast_q <= HEIGHT_REG_W'(2);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH:  wlast_q <= wlast_d;
				CFG_IMAGE_HEIGHT: hlast_q <= hlast_d;
				default: ;
			endcase
		end
	end

	assign col_last = col_q >= wlast_q;
	assign row_last = row_q >= hlast_q;
	assign col_next = col_last ? '0 : col_q + CW'(1);
	// prefetch: the line stores always present the entry of the coming column
	assign rd_addr  = accept ? col_next : col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			col_q <= col_next;
			if (col_last) begin
				row_q <= row_last ? '0 : row_q + HEIGHT_REG_W'(1);
			end
		end
	end

	rilbp_ram #(
		.WIDTH(PIXEL_BITS),
		.DEPTH(MAX_WIDTH)
	) u_line_aa (
		.clk    (clk),
		.wr_en  (accept),
		.wr_addr(col_q),
		.wr_data(mid),
		.rd_addr(rd_addr),
		.rd_data(top)
	);

	rilbp_ram #(
		.WIDTH(PIXEL_BITS),
		.DEPTH(MAX_WIDTH)
	) u_line_a (
		.clk    (clk),
		.wr_en  (accept),
		.wr_addr(col_q),
		.wr_data(bot),
		.rd_addr(rd_addr),
		.rd_data(mid)
	);

	// window columns: 0..2 oldest column (top, mid, bottom), 3..5 middle column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (accept) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top;
			win_q[4] <= mid;
			win_q[5] <= bot;
		end
	end

	// clockwise from top-left
	assign nbr[0] = win_q[0];
	assign nbr[1] = win_q[3];
	assign nbr[2] = top;
	assign nbr[3] = mid;
	assign nbr[4] = bot;
	assign nbr[5] = win_q[5];
	assign nbr[6] = win_q[2];
	assign nbr[7] = win_q[1];
	assign ctr    = win_q[4];

	assign ctl.interior = (row_q >= HEIGHT_REG_W'(2)) && (col_q >= CW'(2));
	assign ctl.row_end  = col_last;
	assign ctl.last     = col_last && row_last;

endmodule

@@ rtl/rilbp_checker.sv @@
// port-level checks for rotation_invariant_lbp_3x3_core and the bind that
// attaches them; depends on rilbp_pkg
module rilbp_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [rilbp_pkg::CODE_W-1:0]      lbp_code,
	input logic                              row_end,
	input logic                              last
);
	import rilbp_pkg::*;

	// a code is rotation-minimal when it equals its own rotation minimum
	function automatic logic is_min_rot(input logic [CODE_W-1:0] code);
		return min_rotation(code) == code;
	endfunction

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(lbp_code) && $stable(last))
	else $error("stalled transaction changed");

	a_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> row_end)
	else $error("frame end without row end");

	a_min_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> is_min_rot(lbp_code))
	else $error("lbp code is not a rotation minimum");

	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
	else $error("input stalled with empty output register");

endmodule

bind rotation_invariant_lbp_3x3_core rilbp_checker u_rilbp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_stall (in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.lbp_code (lbp_code),
	.row_end  (row_end),
	.last     (last)
);
